// ===== src/bounded_stack_engine_top_assert.svh =====
// ----------------------------------------------------------------------------
// Stack engine assertion macros
// Clocked property wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_STACK_ENGINE_TOP_ASSERT_SVH
`define BOUNDED_STACK_ENGINE_TOP_ASSERT_SVH

// property checked outside reset only
`define BSE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define BSE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/bse_pkg.sv =====
// ----------------------------------------------------------------------------
// Stack engine package
// Fixed field widths, operation and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package bse_pkg;

    localparam int CAP_W   = 9;
    localparam int VALUE_W = 32;
    localparam int INDEX_W = 8;

    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_PEEK = 2'd2,
        OP_EDIT = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_ZERO  = 2'd3
    } t_status;

endpackage

`default_nettype wire

// ===== src/bse_if.sv =====
// ----------------------------------------------------------------------------
// Stack engine channels
// Request and response interfaces with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface bse_in_if import bse_pkg::*;
    ;
    logic                      valid;
    logic                      ready;
    t_op                       operation;
    logic signed [VALUE_W-1:0] value;
    logic [INDEX_W-1:0]        index;

    modport source (output valid, output operation, output value, output index,
                    input ready);
    modport sink   (input valid, input operation, input value, input index,
                    output ready);
endinterface

interface bse_out_if import bse_pkg::*;
    ;
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] data;
    t_status                   status;
    logic [CAP_W-1:0]          depth_used;
    logic                      is_empty;
    logic                      is_full;

    modport source (output valid, output data, output status, output depth_used,
                    output is_empty, output is_full, input ready);
    modport sink   (input valid, input data, input status, input depth_used,
                    input is_empty, input is_full, output ready);
endinterface

`default_nettype wire

// ===== src/bounded_stack_engine_top.sv =====
// ----------------------------------------------------------------------------
// Bounded stack engine
// LIFO of DEPTH words with push, pop, peek and edit, one response per request.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one request word (operation, value, index); o_rsp returns
//   exactly one response word per request, in order (data, status, count,
//   empty and full flags). i_cfg_we/i_cfg_wdata set the capacity in use;
//   write it only while no request is in flight.
//   The request is held in the read stage, then its response in the response
//   register. Throughput: one request per cycle while o_rsp is drained.
//   The count is resolved when a request is taken; the entry is read from
//   the single-port-read RAM, modified and written back by the read stage, with
//   a bypass register covering a read of the entry written in the same cycle.
//   Reset: i_rst_n is synchronous, active low. After reset a clearing pass
//   zeroes store entries 0 to DEPTH-1, one entry per cycle; i_req.ready
//   stays low until it ends. Capacity writes are taken during the pass.
//   Stall: the response register holds while o_rsp.ready is low; one more
//   request may sit in the read stage, then i_req.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_stack_engine_top import bse_pkg::*; #(
    parameter int DEPTH     = 256,
    parameter int WORD_BITS = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CAP_W-1:0] i_cfg_wdata,
    bse_in_if.sink                i_req,
    bse_out_if.source             o_rsp
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int CMP_W = (CW > CAP_W) ? CW : CAP_W;

    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);
    localparam logic [AW-1:0]    LAST_A  = AW'(DEPTH - 1);

    typedef enum logic [1:0] {
        S_CLEAR = 2'b01,
        S_RUN   = 2'b10
    } t_state;

    t_state               r_state;
    logic [AW-1:0]        r_clr_addr;
    logic [CAP_W-1:0]     r_cap;
    logic [CMP_W-1:0]     r_cnt;

    // read stage
    logic                 r_s2_valid;
    t_op                  r_s2_op;
    logic [WORD_BITS-1:0] r_s2_val;
    logic [AW-1:0]        r_s2_addr;
    logic                 r_s2_ok;
    t_status              r_s2_status;
    logic [CAP_W-1:0]     r_s2_depth;
    logic                 r_s2_empty;
    logic                 r_s2_full;
    logic                 r_fwd_hit;
    logic [WORD_BITS-1:0] r_fwd_data;

    // response register
    logic                 r_out_valid;
    logic [VALUE_W-1:0]   r_out_data;
    t_status              r_out_status;
    logic [CAP_W-1:0]     r_out_depth;
    logic                 r_out_empty;
    logic                 r_out_full;

    logic [CMP_W-1:0]     ucap;
    logic [CMP_W-1:0]     cap_ext;
    logic                 cnt_full;
    logic                 cnt_zero;
    logic                 idx_ok;
    logic                 accept;
    logic                 s2_move;

    logic                 n_ok;
    t_status              n_status;
    logic [CMP_W-1:0]     n_cnt;
    logic [AW-1:0]        rd_addr;

    logic [WORD_BITS-1:0] ram_q;
    logic [WORD_BITS-1:0] rd_word;
    logic [WORD_BITS-1:0] s2_data;
    logic [WORD_BITS-1:0] s2_wdata;
    logic                 s2_wreq;
    logic                 s2_we;
    t_status              s2_status;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;

    // ---------------- request stage: count, flags, read address -------------

    always_comb begin
        cap_ext = CMP_W'(r_cap);
        if (cap_ext == '0) begin
            ucap = CMP_W'(1);
        end else if (cap_ext > DEPTH_C) begin
            ucap = DEPTH_C;
        end else begin
            ucap = cap_ext;
        end
    end

    assign cnt_full = (r_cnt >= ucap);
    assign cnt_zero = (r_cnt == '0);
    assign idx_ok   = (CMP_W'(i_req.index) < DEPTH_C);

    always_comb begin
        n_ok     = 1'b0;
        n_status = ST_OK;
        n_cnt    = r_cnt;
        rd_addr  = AW'(i_req.index);
        case (i_req.operation)
            OP_PUSH: begin
                n_ok     = !cnt_full;
                n_status = cnt_full ? ST_FULL : ST_OK;
                n_cnt    = cnt_full ? r_cnt : r_cnt + CMP_W'(1);
                rd_addr  = AW'(r_cnt);
            end
            OP_POP: begin
                n_ok     = !cnt_zero;
                n_status = cnt_zero ? ST_EMPTY : ST_OK;
                n_cnt    = cnt_zero ? r_cnt : r_cnt - CMP_W'(1);
                rd_addr  = AW'(r_cnt - CMP_W'(1));
            end
            OP_PEEK: begin
                n_ok     = !cnt_zero && idx_ok;
                n_status = cnt_zero ? ST_EMPTY : ST_OK;
            end
            OP_EDIT: begin
                n_ok     = idx_ok;
                n_status = idx_ok ? ST_OK : ST_ZERO;
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    assign s2_move     = r_s2_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = (r_state == S_RUN) && (!r_s2_valid || s2_move);
    assign accept      = i_req.valid && i_req.ready;

    // ---------------- read-modify-write stage -------------------------------

    assign rd_word = r_fwd_hit ? r_fwd_data : ram_q;

    always_comb begin
        s2_data   = '0;
        s2_wdata  = r_s2_val;
        s2_wreq   = 1'b0;
        s2_status = r_s2_status;
        case (r_s2_op)
            OP_PUSH: begin
                s2_wreq = r_s2_ok;
            end
            OP_POP: begin
                s2_wdata = '0;
                s2_wreq  = r_s2_ok;
                s2_data  = r_s2_ok ? rd_word : '0;
            end
            OP_PEEK: begin
                s2_data = r_s2_ok ? rd_word : '0;
            end
            OP_EDIT: begin
                if (!r_s2_ok || rd_word == '0) begin
                    s2_status = ST_ZERO;
                end else begin
                    s2_wreq = 1'b1;
                    s2_data = rd_word;
                end
            end
            default: begin
                s2_wreq = 1'b0;
            end
        endcase
    end

    assign s2_we = s2_move && s2_wreq;

    // clearing pass owns the write port until it ends
    always_comb begin
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = s2_we;
            ram_waddr = r_s2_addr;
            ram_wdata = s2_wdata;
        end
    end

    bse_ram #(
        .AW (AW),
        .WW (WORD_BITS)
    ) u_bse_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    // ---------------- control registers -------------------------------------

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == LAST_A) begin
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_state <= S_RUN;
                end
                default: begin
                    r_state    <= S_CLEAR;
                    r_clr_addr <= '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_s2_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_cnt      <= n_cnt;
                r_s2_valid <= 1'b1;
            end else if (s2_move) begin
                r_s2_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s2_op     <= i_req.operation;
            r_s2_val    <= WORD_BITS'($unsigned(i_req.value));
            r_s2_addr   <= rd_addr;
            r_s2_ok     <= n_ok;
            r_s2_status <= n_status;
            r_s2_depth  <= n_cnt[CAP_W-1:0];
            r_s2_empty  <= (n_cnt == '0);
            r_s2_full   <= (n_cnt >= ucap);
            r_fwd_hit   <= s2_we && (r_s2_addr == rd_addr);
            r_fwd_data  <= s2_wdata;
        end
    end

    // ---------------- response register -------------------------------------

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_move) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_move) begin
            r_out_data   <= VALUE_W'(s2_data);
            r_out_status <= s2_status;
            r_out_depth  <= r_s2_depth;
            r_out_empty  <= r_s2_empty;
            r_out_full   <= r_s2_full;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.data       = $signed(r_out_data);
    assign o_rsp.status     = r_out_status;
    assign o_rsp.depth_used = r_out_depth;
    assign o_rsp.is_empty   = r_out_empty;
    assign o_rsp.is_full    = r_out_full;

endmodule

`default_nettype wire

// ===== src/bse_ram.sv =====
// ----------------------------------------------------------------------------
// Stack engine entry store
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bse_ram #(
    parameter int AW = 8,
    parameter int WW = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [WW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [WW-1:0] o_rdata
);

    logic [WW-1:0] r_mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read before write on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/bse_checker.sv =====
// ----------------------------------------------------------------------------
// Stack engine port checker
// Response consistency and reset behaviour seen at the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bounded_stack_engine_top_assert.svh"

module bse_checker import bse_pkg::*; (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_req_ready,
    input wire logic               i_rsp_valid,
    input wire logic               i_rsp_ready,
    input wire logic [VALUE_W-1:0] i_rsp_data,
    input wire logic [1:0]         i_rsp_status,
    input wire logic [CAP_W-1:0]   i_rsp_depth,
    input wire logic               i_rsp_empty,
    input wire logic               i_rsp_full
);

    // empty flag tracks the reported count
    `BSE_ASSERT(a_empty_count, i_clk, i_rst_n, i_rsp_valid |-> (i_rsp_empty == (i_rsp_depth == '0)), "empty flag disagrees with count")

    // a rejected push only happens on a full stack and returns no word
    `BSE_ASSERT(a_full_push, i_clk, i_rst_n, (i_rsp_valid && i_rsp_status == ST_FULL) |-> (i_rsp_full && i_rsp_data == '0), "full status without full stack")

    // an empty failure leaves the stack empty and returns no word
    `BSE_ASSERT(a_empty_fail, i_clk, i_rst_n, (i_rsp_valid && i_rsp_status == ST_EMPTY) |-> (i_rsp_empty && i_rsp_data == '0), "empty status on non-empty stack")

    `BSE_ASSERT(a_rsp_hold, i_clk, i_rst_n, (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_rsp_data) && $stable(i_rsp_status)), "stalled response changed")

    // clearing pass keeps requests out right after reset
    `BSE_ASSERT_ALWAYS(a_reset_blocks, i_clk, !i_rst_n |=> !i_req_ready, "request taken before store cleared")

endmodule

bind bounded_stack_engine_top bse_checker u_bse_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_data   (o_rsp.data),
    .i_rsp_status (o_rsp.status),
    .i_rsp_depth  (o_rsp.depth_used),
    .i_rsp_empty  (o_rsp.is_empty),
    .i_rsp_full   (o_rsp.is_full)
);

`default_nettype wire

// ===== verif/bounded_stack_engine_top_tb.sv =====
// ----------------------------------------------------------------------------
// Bounded stack engine testbench
// Sends push, pop, peek and edit requests under several capacity settings.
// A local stack model predicts every response, and each response is checked
// field by field against it. Both channels stall at random, and one long
// receiver hold-off fills the pipeline.
// ----------------------------------------------------------------------------
module bounded_stack_engine_top_tb;
    import bse_pkg::*;

    localparam int STACK_DEPTH = 256;
    localparam int IDLE_PCT    = 9;
    localparam int HOLD_AT     = 120;
    localparam int HOLD_CYCLES = 60;
    localparam int DRAIN_WAIT  = 10;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        t_op                op;
        logic [VALUE_W-1:0] val;
        logic [INDEX_W-1:0] idx;
    } stack_req_t;

    typedef struct packed {
        logic [VALUE_W-1:0] data;
        t_status            status;
        logic [CAP_W-1:0]   depth;
        logic               empty;
        logic               full;
    } stack_rsp_t;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             cfg_we;
    logic [CAP_W-1:0] cfg_wdata;

    bse_in_if  req_if ();
    bse_out_if rsp_if ();

    bounded_stack_engine_top #(
        .DEPTH     (STACK_DEPTH),
        .WORD_BITS (VALUE_W)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    always #5 i_clk = ~i_clk;

    // stack model, advanced when a request word is taken
    logic [VALUE_W-1:0] model_mem [0:STACK_DEPTH-1];
    int                 model_cnt;
    int                 model_cap;

    // stimulus-side view of the fill level, used to steer the generator
    int gen_cnt;
    int gen_lim;

    stack_req_t pending_reqs [$];
    stack_rsp_t expected_rsps [$];
    stack_req_t drv_next;
    stack_rsp_t rsp_want;

    int reqs_queued = 0;
    int reqs_taken  = 0;
    int rsp_seen    = 0;
    int err_count   = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;
    logic calm;

    // a stretch of traffic with no idling on either side
    assign calm = (reqs_taken >= 400) && (reqs_taken < 480);

    function automatic int usable_cap(int c);
        if (c == 0)
            return 1;
        if (c > STACK_DEPTH)
            return STACK_DEPTH;
        return c;
    endfunction

    function automatic stack_rsp_t apply_request(t_op op, logic [VALUE_W-1:0] val,
                                                 logic [INDEX_W-1:0] idx);
        stack_rsp_t r;
        int         lim;
        lim      = usable_cap(model_cap);
        r.data   = '0;
        r.status = ST_OK;
        case (op)
            OP_PUSH: begin
                if (model_cnt >= lim) begin
                    r.status = ST_FULL;
                end else begin
                    model_mem[model_cnt] = val;
                    model_cnt++;
                end
            end
            OP_POP: begin
                if (model_cnt == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    model_cnt--;
                    r.data = model_mem[model_cnt];
                    model_mem[model_cnt] = '0;
                end
            end
            OP_PEEK: begin
                if (model_cnt == 0)
                    r.status = ST_EMPTY;
                else
                    r.data = model_mem[idx];
            end
            default: begin
                // edit only lands on a nonzero word, wherever it sits
                if (model_mem[idx] == '0) begin
                    r.status = ST_ZERO;
                end else begin
                    r.data = model_mem[idx];
                    model_mem[idx] = val;
                end
            end
        endcase
        r.depth = CAP_W'(model_cnt);
        r.empty = (model_cnt == 0);
        r.full  = (model_cnt >= lim);
        return r;
    endfunction

    function automatic void note_fail(string msg);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("MISMATCH: %s", msg);
    endfunction

    function automatic void queue_request(t_op op, logic [VALUE_W-1:0] val,
                                          logic [INDEX_W-1:0] idx);
        stack_req_t q;
        q.op  = op;
        q.val = val;
        q.idx = idx;
        pending_reqs.push_back(q);
        reqs_queued++;
        if (op == OP_PUSH && gen_cnt < gen_lim)
            gen_cnt++;
        else if (op == OP_POP && gen_cnt > 0)
            gen_cnt--;
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return '0;
        if (r < 14) begin
            case ($urandom_range(3))
                0: return 32'h8000_0000;
                1: return 32'h7fff_ffff;
                2: return 32'hffff_ffff;
                default: return 32'h0000_0001;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [INDEX_W-1:0] pick_index();
        if (gen_cnt > 0 && $urandom_range(99) < 70)
            return INDEX_W'($urandom_range(gen_cnt - 1, 0));
        return INDEX_W'($urandom_range(STACK_DEPTH - 1, 0));
    endfunction

    // weights in percent for push, pop and peek; edit takes the remainder
    function automatic void queue_random(int w_push, int w_pop, int w_peek);
        int  r;
        t_op op;
        r = $urandom_range(99);
        if (r < w_push)
            op = OP_PUSH;
        else if (r < w_push + w_pop)
            op = OP_POP;
        else if (r < w_push + w_pop + w_peek)
            op = OP_PEEK;
        else
            op = OP_EDIT;
        queue_request(op, pick_value(), pick_index());
    endfunction

    task automatic wait_idle();
        while (reqs_taken != reqs_queued || expected_rsps.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_capacity(logic [CAP_W-1:0] cap);
        wait_idle();
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        model_cap = cap;
        gen_lim   = usable_cap(cap);
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                expected_rsps.push_back(apply_request(req_if.operation, req_if.value,
                                                      req_if.index));
                reqs_taken <= reqs_taken + 1;
            end
            if (!req_if.valid || req_if.ready) begin
                if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    drv_next = pending_reqs.pop_front();
                    req_if.valid     <= 1'b1;
                    req_if.operation <= drv_next.op;
                    req_if.value     <= drv_next.val;
                    req_if.index     <= drv_next.idx;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // response back-pressure, with one long hold-off while requests keep coming
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            rsp_if.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (!hold_done && rsp_seen >= HOLD_AT) begin
            rsp_if.ready <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            hold_done    <= 1'b1;
        end else begin
            rsp_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // response monitor
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            rsp_seen <= rsp_seen + 1;
            if (expected_rsps.size() == 0) begin
                note_fail($sformatf("response word %0d arrived with none outstanding",
                                    rsp_seen));
            end else begin
                rsp_want = expected_rsps.pop_front();
                if (rsp_if.data !== rsp_want.data || rsp_if.status !== rsp_want.status ||
                    rsp_if.depth_used !== rsp_want.depth ||
                    rsp_if.is_empty !== rsp_want.empty || rsp_if.is_full !== rsp_want.full)
                    note_fail($sformatf({"word %0d: got data %h status %0d count %0d ",
                        "empty %b full %b; want data %h status %0d count %0d empty %b full %b"},
                        rsp_seen, rsp_if.data, rsp_if.status, rsp_if.depth_used,
                        rsp_if.is_empty, rsp_if.is_full, rsp_want.data, rsp_want.status,
                        rsp_want.depth, rsp_want.empty, rsp_want.full));
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        req_if.valid     = 1'b0;
        req_if.operation = OP_PUSH;
        req_if.value     = '0;
        req_if.index     = '0;
        rsp_if.ready     = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        i_rst_n          = 1'b0;
        for (int i = 0; i < STACK_DEPTH; i++)
            model_mem[i] = '0;
        model_cnt = 0;
        model_cap = CAP_RESET;
        gen_cnt   = 0;
        gen_lim   = usable_cap(CAP_RESET);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // small stack: empty, full and edit corner cases
        set_capacity(9'd4);
        queue_request(OP_POP,  32'h0,         8'd0);
        queue_request(OP_PEEK, 32'h0,         8'd0);
        queue_request(OP_EDIT, 32'h1,         8'd5);
        queue_request(OP_PUSH, 32'h8000_0000, 8'd0);
        queue_request(OP_PUSH, 32'h7fff_ffff, 8'd0);
        queue_request(OP_PUSH, 32'h0,         8'd0);
        queue_request(OP_PUSH, 32'hffff_ffff, 8'd0);
        queue_request(OP_PUSH, 32'h1234_5678, 8'd0);
        queue_request(OP_PEEK, 32'h0,         8'd0);
        queue_request(OP_PEEK, 32'h0,         8'd255);
        queue_request(OP_EDIT, 32'h5,         8'd2);
        queue_request(OP_EDIT, 32'h0,         8'd1);
        queue_request(OP_EDIT, 32'h9,         8'd1);
        queue_request(OP_EDIT, 32'h5555_5555, 8'd3);
        queue_request(OP_POP,  32'h0,         8'd0);

        // capacity dropped below the fill level: reads as full, entries kept
        set_capacity(9'd2);
        queue_request(OP_PUSH, 32'hdead_beef, 8'd0);
        queue_request(OP_PEEK, 32'h0,         8'd2);
        queue_request(OP_POP,  32'h0,         8'd0);
        queue_request(OP_POP,  32'h0,         8'd0);
        queue_request(OP_EDIT, 32'haaaa_aaaa, 8'd0);
        queue_request(OP_POP,  32'h0,         8'd0);
        queue_request(OP_EDIT, 32'h3,         8'd3);

        // zero capacity behaves as one entry
        set_capacity(9'd0);
        queue_request(OP_PUSH, 32'h1, 8'd0);
        queue_request(OP_PUSH, 32'h2, 8'd0);
        queue_request(OP_POP,  32'h0, 8'd0);

        // oversize setting clamps to the full store; fill it to the top
        set_capacity(9'd511);
        while (gen_cnt < gen_lim)
            queue_random(94, 0, 3);
        repeat (8)
            queue_random(70, 10, 10);

        set_capacity(9'd20);
        repeat (25)
            queue_random(30, 30, 20);

        set_capacity(9'd1);
        repeat (15)
            queue_random(30, 30, 20);

        // empty it again, mostly pops
        set_capacity(9'd256);
        while (gen_cnt > 0)
            queue_random(2, 92, 3);
        repeat (6)
            queue_random(10, 70, 10);

        set_capacity(9'd3);
        repeat (40)
            queue_random(35, 30, 20);

        set_capacity(CAP_W'($urandom_range(40, 5)));
        repeat (30)
            queue_random(35, 30, 20);

        wait_idle();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (expected_rsps.size() != 0)
            note_fail($sformatf("%0d responses never arrived", expected_rsps.size()));

        $display("Run covered %0d requests and %0d checked responses, %0d mismatches.",
                 reqs_taken, rsp_seen, err_count);
        $display("Capacities 0, 1, 2, 3, 4, 20, 256, 511 and one random; fill to 256 and back.");
        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
